/* src/i2cms_pkg.sv */
// shared types, opcodes and phase helpers of the i2c master bit sequencer
// no dependencies; imported by the top level, the front, the engine and the testbench
package i2cms_pkg;

   localparam int QueueDepthDefault = 2;
   localparam logic [15:0] HoldTicksReset = 16'd8;

   localparam logic [2:0] OP_START     = 3'd0;
   localparam logic [2:0] OP_STOP      = 3'd1;
   localparam logic [2:0] OP_SEND_BYTE = 3'd2;
   localparam logic [2:0] OP_RECV_BYTE = 3'd3;
   localparam logic [2:0] OP_SEND_ACK  = 3'd4;
   localparam logic [2:0] OP_RECV_ACK  = 3'd5;

   typedef struct packed {
      logic       start;
      logic [2:0] opcode;
      logic [7:0] tx_byte;
      logic       ack_to_send;
      logic       sda_sample;
   } tick_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       sda_drive;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       ack_in;
   } result_type;

   typedef struct packed {
      logic [2:0] quot;
      logic [1:0] rem;
   } div3_type;

   // bit slot and step within a three-phase bit slot
   function automatic div3_type div3(input logic [4:0] p);
      div3_type r;
      logic [4:0] base;
      r.quot = 3'd0;
      for (int k = 1; k < 8; k++) begin
         if (p >= 5'(3 * k)) begin
            r.quot = 3'(k);
         end
      end
      base = 5'({2'b00, r.quot}) * 5'd3;
      r.rem = 2'(p - base);
      return r;
   endfunction

   function automatic logic [5:0] phase_count(input logic [2:0] op);
      logic [5:0] n;
      unique case (op)
         OP_START:     n = 6'd4;
         OP_STOP:      n = 6'd3;
         OP_SEND_BYTE: n = 6'd24;
         OP_RECV_BYTE: n = 6'd25;
         OP_SEND_ACK:  n = 6'd3;
         default:      n = 6'd4;
      endcase
      return n;
   endfunction

endpackage

/* src/i2c_master_bit_sequencer.sv */
// I2C master bit sequencer. Every request is one bus-timer tick and yields
// exactly one response with the pin levels after that tick. Sustained rate is
// one tick per clock while the result queue has room; a tick is registered in
// the request queue, and the engine updates its state and queues the response
// at the edge that pops the tick. The engine takes a tick whenever one is
// queued and the result queue is not full. Both queues hold QUEUE_DEPTH
// entries. csr_ready is always high; the user must write hold_ticks only
// while no command is running, and the block itself does not enforce it.
// depends on i2cms_pkg, i2cms_front, i2cms_engine
module i2c_master_bit_sequencer #(
   parameter int QUEUE_DEPTH = i2cms_pkg::QueueDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_cmd_valid,
   input  logic [2:0]  req_opcode,
   input  logic [7:0]  req_tx_byte,
   input  logic        req_ack_to_send,
   input  logic        req_sda_sample,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_scl_out,
   output logic        rsp_sda_out,
   output logic        rsp_sda_drive,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic [7:0]  rsp_rx_byte,
   output logic        rsp_ack_in,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_hold_ticks
);
   import i2cms_pkg::*;

   tick_type   tick_data;
   logic       tick_valid, tick_pop;
   result_type rsp_data;

   i2cms_front #(
      .DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (req_push),
      .full        (req_full),
      .cmd_valid   (req_cmd_valid),
      .opcode      (req_opcode),
      .tx_byte     (req_tx_byte),
      .ack_to_send (req_ack_to_send),
      .sda_sample  (req_sda_sample),
      .tick_valid  (tick_valid),
      .tick_pop    (tick_pop),
      .tick_data   (tick_data)
   );

   i2cms_engine #(
      .DEPTH (QUEUE_DEPTH)
   ) u_engine (
      .clock          (clock),
      .reset          (reset),
      .tick_valid     (tick_valid),
      .tick_pop       (tick_pop),
      .tick_data      (tick_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_hold_ticks (csr_hold_ticks),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_data       (rsp_data)
   );

   assign rsp_scl_out   = rsp_data.scl_out;
   assign rsp_sda_out   = rsp_data.sda_out;
   assign rsp_sda_drive = rsp_data.sda_drive;
   assign rsp_busy_res  = rsp_data.busy_res;
   assign rsp_done_res  = rsp_data.done_res;
   assign rsp_rx_byte   = rsp_data.rx_byte;
   assign rsp_ack_in    = rsp_data.ack_in;

endmodule

/* src/i2cms_fifo.sv */
// small first-in first-out queue of register slots, any payload type
// depends on nothing; used by the front and the engine
module i2cms_fifo #(
   parameter int DEPTH = 2,
   parameter type item_type = logic
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   output logic     full,
   input  item_type push_data,
   input  logic     pop,
   output logic     empty,
   output item_type pop_data
);
   localparam int PtrW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] LastSlot = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] FullCount = CntW'(DEPTH);

   item_type        slot_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign full     = (count_ff == FullCount);
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastSlot) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastSlot) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* src/i2cms_front.sv */
// request side: takes ticks, flags valid commands, queues them for the engine
// depends on i2cms_pkg and i2cms_fifo
module i2cms_front #(
   parameter int DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  logic                cmd_valid,
   input  logic [2:0]          opcode,
   input  logic [7:0]          tx_byte,
   input  logic                ack_to_send,
   input  logic                sda_sample,
   output logic                tick_valid,
   input  logic                tick_pop,
   output i2cms_pkg::tick_type tick_data
);
   import i2cms_pkg::*;

   tick_type classified;
   logic     tick_empty;

   // opcodes above receive ack never start a command
   always_comb begin
      classified.start       = cmd_valid && (opcode <= OP_RECV_ACK);
      classified.opcode      = opcode;
      classified.tx_byte     = tx_byte;
      classified.ack_to_send = ack_to_send;
      classified.sda_sample  = sda_sample;
   end

   i2cms_fifo #(
      .DEPTH     (DEPTH),
      .item_type (tick_type)
   ) u_tick_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .push_data (classified),
      .pop       (tick_pop),
      .empty     (tick_empty),
      .pop_data  (tick_data)
   );

   assign tick_valid = !tick_empty;

endmodule

/* src/i2cms_engine.sv */
// bus engine: phase sequencing, hold timer, pin state, result queue
// depends on i2cms_pkg and i2cms_fifo
module i2cms_engine #(
   parameter int DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  tick_valid,
   output logic                  tick_pop,
   input  i2cms_pkg::tick_type   tick_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [15:0]           csr_hold_ticks,
   input  logic                  rsp_pop,
   output logic                  rsp_empty,
   output i2cms_pkg::result_type rsp_data
);
   import i2cms_pkg::*;

   logic [15:0] hold_ticks_ff;
   logic [4:0]  phase_ff, phase_in;
   logic [15:0] hold_cnt_ff, hold_cnt_in;
   logic [2:0]  cmd_ff, cmd_in;
   logic [7:0]  shift_ff, shift_in;
   logic        scl_ff, scl_in;
   logic        sda_ff, sda_in;
   logic        drive_ff, drive_in;
   logic        busy_ff, busy_in;
   logic        ack_ff, ack_in;

   logic        out_full, fire, active, done, run_phase;
   logic [15:0] hold_len;
   div3_type    slot_tx, slot_rx;
   result_type  result;

   assign csr_ready = 1'b1;
   assign fire      = tick_valid && !out_full;
   assign tick_pop  = fire;
   assign hold_len  = (hold_ticks_ff == '0) ? 16'd1 : hold_ticks_ff;

   always_comb begin
      phase_in    = phase_ff;
      hold_cnt_in = hold_cnt_ff;
      cmd_in      = cmd_ff;
      shift_in    = shift_ff;
      scl_in      = scl_ff;
      sda_in      = sda_ff;
      drive_in    = drive_ff;
      busy_in     = busy_ff;
      ack_in      = ack_ff;
      active      = 1'b0;
      run_phase   = 1'b0;

      if (busy_ff) begin
         active = 1'b1;
         if (hold_cnt_ff != '0) begin
            hold_cnt_in = hold_cnt_ff - 16'd1;
         end else begin
            phase_in    = phase_ff + 5'd1;
            run_phase   = 1'b1;
            hold_cnt_in = hold_len - 16'd1;
         end
      end else if (tick_data.start) begin
         active      = 1'b1;
         busy_in     = 1'b1;
         cmd_in      = tick_data.opcode;
         phase_in    = '0;
         run_phase   = 1'b1;
         hold_cnt_in = hold_len - 16'd1;
         if (tick_data.opcode == OP_SEND_BYTE) begin
            shift_in = tick_data.tx_byte;
         end else if (tick_data.opcode == OP_RECV_BYTE) begin
            shift_in = '0;
         end
      end

      slot_tx = div3(phase_in);
      slot_rx = div3(phase_in - 5'd1);

      if (run_phase) begin
         unique case (cmd_in)
            OP_START: begin
               if (phase_in == 5'd0) begin
                  drive_in = 1'b1;
                  sda_in   = 1'b1;
               end else if (phase_in == 5'd1) begin
                  scl_in = 1'b1;
               end else if (phase_in == 5'd2) begin
                  drive_in = 1'b1;
                  sda_in   = 1'b0;
               end else begin
                  scl_in = 1'b0;
               end
            end
            OP_STOP: begin
               if (phase_in == 5'd0) begin
                  drive_in = 1'b1;
                  sda_in   = 1'b0;
               end else if (phase_in == 5'd1) begin
                  scl_in = 1'b1;
               end else begin
                  drive_in = 1'b1;
                  sda_in   = 1'b1;
               end
            end
            OP_SEND_BYTE: begin
               if (slot_tx.rem == 2'd0) begin
                  drive_in = 1'b1;
                  sda_in   = shift_in[3'd7 - slot_tx.quot];
               end else if (slot_tx.rem == 2'd1) begin
                  scl_in = 1'b1;
               end else begin
                  scl_in = 1'b0;
               end
            end
            OP_RECV_BYTE: begin
               if (phase_in == 5'd0) begin
                  drive_in = 1'b1;
                  sda_in   = 1'b1;
               end else if (slot_rx.rem == 2'd0) begin
                  drive_in = 1'b0;
                  scl_in   = 1'b1;
               end else if (slot_rx.rem == 2'd1) begin
                  drive_in = 1'b0;
                  shift_in = {shift_in[6:0], tick_data.sda_sample};
               end else begin
                  scl_in = 1'b0;
               end
            end
            OP_SEND_ACK: begin
               if (phase_in == 5'd0) begin
                  drive_in = 1'b1;
                  sda_in   = tick_data.ack_to_send;
               end else if (phase_in == 5'd1) begin
                  scl_in = 1'b1;
               end else begin
                  scl_in = 1'b0;
               end
            end
            default: begin
               if (phase_in == 5'd0) begin
                  drive_in = 1'b1;
                  sda_in   = 1'b1;
               end else if (phase_in == 5'd1) begin
                  scl_in = 1'b1;
               end else if (phase_in == 5'd2) begin
                  drive_in = 1'b0;
                  ack_in   = tick_data.sda_sample;
               end else begin
                  scl_in = 1'b0;
               end
            end
         endcase
      end

      done = active && (hold_cnt_in == '0) &&
             (({1'b0, phase_in} + 6'd1) >= phase_count(cmd_in));
      if (done) begin
         busy_in = 1'b0;
      end

      result.scl_out   = scl_in;
      result.sda_out   = sda_in;
      result.sda_drive = drive_in;
      result.busy_res  = active;
      result.done_res  = done;
      result.rx_byte   = (done && cmd_in == OP_RECV_BYTE) ? shift_in : 8'd0;
      result.ack_in    = done && (cmd_in == OP_RECV_ACK) && ack_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ticks_ff <= HoldTicksReset;
         phase_ff      <= '0;
         hold_cnt_ff   <= '0;
         cmd_ff        <= '0;
         shift_ff      <= '0;
         scl_ff        <= 1'b1;
         sda_ff        <= 1'b1;
         drive_ff      <= 1'b1;
         busy_ff       <= 1'b0;
         ack_ff        <= 1'b0;
      end else begin
         if (csr_valid) begin
            hold_ticks_ff <= csr_hold_ticks;
         end
         if (fire) begin
            phase_ff    <= phase_in;
            hold_cnt_ff <= hold_cnt_in;
            cmd_ff      <= cmd_in;
            shift_ff    <= shift_in;
            scl_ff      <= scl_in;
            sda_ff      <= sda_in;
            drive_ff    <= drive_in;
            busy_ff     <= busy_in;
            ack_ff      <= ack_in;
         end
      end
   end

   i2cms_fifo #(
      .DEPTH     (DEPTH),
      .item_type (result_type)
   ) u_result_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fire),
      .full      (out_full),
      .push_data (result),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .pop_data  (rsp_data)
   );

endmodule

/* src/i2cms_checker.sv */
// port-level checks of the i2c master bit sequencer, bound to the top level
// depends on i2c_master_bit_sequencer ports only
module i2cms_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_full,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic       rsp_scl_out,
   input logic       rsp_sda_drive,
   input logic       rsp_busy_res,
   input logic       rsp_done_res,
   input logic [7:0] rsp_rx_byte,
   input logic       rsp_ack_in
);

   // the response queue comes out of reset empty and the request queue not full
   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_done_res |-> rsp_busy_res)
      else $error("done without busy");

   a_data_done: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && (rsp_rx_byte != 8'd0 || rsp_ack_in) |-> rsp_done_res)
      else $error("received data outside a done response");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_scl_out)
         && $stable(rsp_sda_drive) && $stable(rsp_done_res))
      else $error("stalled response changed");

endmodule

bind i2c_master_bit_sequencer i2cms_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_full      (req_full),
   .rsp_empty     (rsp_empty),
   .rsp_pop       (rsp_pop),
   .rsp_scl_out   (rsp_scl_out),
   .rsp_sda_drive (rsp_sda_drive),
   .rsp_busy_res  (rsp_busy_res),
   .rsp_done_res  (rsp_done_res),
   .rsp_rx_byte   (rsp_rx_byte),
   .rsp_ack_in    (rsp_ack_in)
);

/* tb/tb_i2c_master_bit_sequencer.sv */
// self-checking testbench for the i2c master bit sequencer: drives bus ticks through the
// request queue, predicts pin levels per tick and compares every response in order
// depends on i2cms_pkg and i2c_master_bit_sequencer
module tb_i2c_master_bit_sequencer;
   import i2cms_pkg::*;

   localparam logic [2:0] OP_RSVD_6 = 3'd6;
   localparam logic [2:0] OP_RSVD_7 = 3'd7;
   localparam int unsigned CYCLE_LIMIT = 2_000_000;

   class i2c_pin_scoreboard;
      logic [15:0] hold_ticks;
      int unsigned phase;
      logic [15:0] hold_left;
      logic [2:0]  cmd;
      logic [7:0]  shreg;
      bit          scl;
      bit          sda;
      bit          sda_en;
      bit          busy;
      bit          ack_seen;
      result_type  pins_due[$];
      int          mismatches;
      int          responses;

      function new();
         hold_ticks = HoldTicksReset;
         phase = 0;
         hold_left = '0;
         cmd = OP_START;
         shreg = '0;
         scl = 1'b1;
         sda = 1'b1;
         sda_en = 1'b1;
         busy = 1'b0;
         ack_seen = 1'b0;
         mismatches = 0;
         responses = 0;
      endfunction

      function int phases_of(logic [2:0] op);
         case (op)
            OP_START:     return 4;
            OP_STOP:      return 3;
            OP_SEND_BYTE: return 24;
            OP_RECV_BYTE: return 25;
            OP_SEND_ACK:  return 3;
            default:      return 4;
         endcase
      endfunction

      function void set_sda(bit level);
         sda_en = 1'b1;
         sda = level;
      endfunction

      function void run_phase(int p, bit ack_bit, bit sample);
         int s;
         case (cmd)
            OP_START: begin
               if (p == 0) set_sda(1'b1);
               else if (p == 1) scl = 1'b1;
               else if (p == 2) set_sda(1'b0);
               else scl = 1'b0;
            end
            OP_STOP: begin
               if (p == 0) set_sda(1'b0);
               else if (p == 1) scl = 1'b1;
               else set_sda(1'b1);
            end
            OP_SEND_BYTE: begin
               s = p % 3;
               if (s == 0) set_sda(shreg[7 - ((p / 3) & 7)]);
               else if (s == 1) scl = 1'b1;
               else scl = 1'b0;
            end
            OP_RECV_BYTE: begin
               if (p == 0) begin
                  set_sda(1'b1);
               end else begin
                  s = (p - 1) % 3;
                  if (s == 0) begin
                     sda_en = 1'b0;
                     scl = 1'b1;
                  end else if (s == 1) begin
                     sda_en = 1'b0;
                     shreg = {shreg[6:0], sample};
                  end else begin
                     scl = 1'b0;
                  end
               end
            end
            OP_SEND_ACK: begin
               if (p == 0) set_sda(ack_bit);
               else if (p == 1) scl = 1'b1;
               else scl = 1'b0;
            end
            default: begin
               if (p == 0) set_sda(1'b1);
               else if (p == 1) scl = 1'b1;
               else if (p == 2) begin
                  sda_en = 1'b0;
                  ack_seen = sample;
               end else scl = 1'b0;
            end
         endcase
      endfunction

      // pin levels after one bus tick
      function result_type advance_bus(tick_type t);
         result_type r;
         logic [15:0] h;
         bit active;
         bit done;
         h = (hold_ticks == 16'd0) ? 16'd1 : hold_ticks;
         active = 1'b0;
         done = 1'b0;
         if (busy) begin
            active = 1'b1;
            if (hold_left > 0) begin
               hold_left = hold_left - 16'd1;
            end else begin
               phase = (phase + 1) & 31;
               run_phase(phase, t.ack_to_send, t.sda_sample);
               hold_left = h - 16'd1;
            end
         end else if (t.start && t.opcode <= OP_RECV_ACK) begin
            active = 1'b1;
            busy = 1'b1;
            cmd = t.opcode;
            phase = 0;
            if (t.opcode == OP_SEND_BYTE) shreg = t.tx_byte;
            else if (t.opcode == OP_RECV_BYTE) shreg = '0;
            run_phase(0, t.ack_to_send, t.sda_sample);
            hold_left = h - 16'd1;
         end
         if (active && hold_left == 0 && phase + 1 >= phases_of(cmd)) begin
            done = 1'b1;
            busy = 1'b0;
         end
         r.scl_out = scl;
         r.sda_out = sda;
         r.sda_drive = sda_en;
         r.busy_res = active;
         r.done_res = done;
         r.rx_byte = (done && cmd == OP_RECV_BYTE) ? shreg : 8'd0;
         r.ack_in = (done && cmd == OP_RECV_ACK) ? ack_seen : 1'b0;
         return r;
      endfunction

      function void note_tick(tick_type t);
         pins_due.push_back(advance_bus(t));
      endfunction

      task report(string msg);
         $display("ERROR response %0d: %s", responses, msg);
         mismatches++;
      endtask

      task compare(string name, logic [7:0] got, logic [7:0] want);
         if (got !== want)
            report($sformatf("%s got %0h want %0h", name, got, want));
      endtask

      task check_pins(result_type got);
         result_type want;
         if (pins_due.size() == 0) begin
            report("response with no request outstanding");
         end else begin
            want = pins_due.pop_front();
            compare("scl_out", 8'(got.scl_out), 8'(want.scl_out));
            compare("sda_out", 8'(got.sda_out), 8'(want.sda_out));
            compare("sda_drive", 8'(got.sda_drive), 8'(want.sda_drive));
            compare("busy_res", 8'(got.busy_res), 8'(want.busy_res));
            compare("done_res", 8'(got.done_res), 8'(want.done_res));
            compare("rx_byte", got.rx_byte, want.rx_byte);
            compare("ack_in", 8'(got.ack_in), 8'(want.ack_in));
         end
         responses++;
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic        req_cmd_valid;
   logic [2:0]  req_opcode;
   logic [7:0]  req_tx_byte;
   logic        req_ack_to_send;
   logic        req_sda_sample;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic        rsp_scl_out;
   logic        rsp_sda_out;
   logic        rsp_sda_drive;
   logic        rsp_busy_res;
   logic        rsp_done_res;
   logic [7:0]  rsp_rx_byte;
   logic        rsp_ack_in;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_hold_ticks;

   i2c_pin_scoreboard sb = new();
   int unsigned cycles = 0;
   int          burst_left = 0;
   int          stall_left = 0;
   logic [2:0]  op_script[$];

   i2c_master_bit_sequencer DUT (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_cmd_valid   (req_cmd_valid),
      .req_opcode      (req_opcode),
      .req_tx_byte     (req_tx_byte),
      .req_ack_to_send (req_ack_to_send),
      .req_sda_sample  (req_sda_sample),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_scl_out     (rsp_scl_out),
      .rsp_sda_out     (rsp_sda_out),
      .rsp_sda_drive   (rsp_sda_drive),
      .rsp_busy_res    (rsp_busy_res),
      .rsp_done_res    (rsp_done_res),
      .rsp_rx_byte     (rsp_rx_byte),
      .rsp_ack_in      (rsp_ack_in),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_hold_ticks  (csr_hold_ticks)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty)
         sb.check_pins('{scl_out: rsp_scl_out, sda_out: rsp_sda_out,
                         sda_drive: rsp_sda_drive, busy_res: rsp_busy_res,
                         done_res: rsp_done_res, rx_byte: rsp_rx_byte,
                         ack_in: rsp_ack_in});
   end

   // receiver stalls: free-running, periodic, random, and long random stalls
   always @(negedge clock) begin
      case (cycles[10:9])
         2'd0: rsp_pop <= 1'b1;
         2'd1: rsp_pop <= (cycles % 3) != 0;
         2'd2: rsp_pop <= $urandom_range(0, 9) > 3;
         default: begin
            if (stall_left > 0) begin
               stall_left <= stall_left - 1;
               rsp_pop <= 1'b0;
            end else if ($urandom_range(0, 11) == 0) begin
               stall_left <= $urandom_range(1, 20);
               rsp_pop <= 1'b0;
            end else begin
               rsp_pop <= 1'b1;
            end
         end
      endcase
   end

   initial begin
      wait (cycles >= CYCLE_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   // called at a falling edge, returns at a falling edge with push still high
   task automatic send_tick(tick_type t);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_push <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 30);
      end
      burst_left--;
      req_cmd_valid <= t.start;
      req_opcode <= t.opcode;
      req_tx_byte <= t.tx_byte;
      req_ack_to_send <= t.ack_to_send;
      req_sda_sample <= t.sda_sample;
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
      sb.note_tick(t);
      @(negedge clock);
   endtask

   task automatic run_cmd(logic [2:0] op, logic [7:0] tx, logic ack, int sda_mode,
                          bit noise);
      tick_type t;
      t.start = 1'b1;
      t.opcode = op;
      t.tx_byte = tx;
      t.ack_to_send = ack;
      t.sda_sample = (sda_mode == 2) ? 1'($urandom) : 1'(sda_mode);
      send_tick(t);
      while (sb.busy) begin
         t.start = noise;
         t.opcode = 3'($urandom);
         t.tx_byte = 8'($urandom);
         t.ack_to_send = 1'($urandom);
         t.sda_sample = (sda_mode == 2) ? 1'($urandom) : 1'(sda_mode);
         send_tick(t);
      end
   endtask

   // mostly whole bus transfers, with some stray opcodes mixed in
   function automatic logic [2:0] next_opcode();
      int n;
      if ($urandom_range(0, 6) == 0) return 3'($urandom);
      if (op_script.size() == 0) begin
         op_script = '{OP_START, OP_SEND_BYTE, OP_RECV_ACK};
         n = $urandom_range(1, 3);
         repeat (n) begin
            if ($urandom_range(0, 1) == 1) begin
               op_script.push_back(OP_SEND_BYTE);
               op_script.push_back(OP_RECV_ACK);
            end else begin
               op_script.push_back(OP_RECV_BYTE);
               op_script.push_back(OP_SEND_ACK);
            end
         end
         op_script.push_back(OP_STOP);
      end
      return op_script.pop_front();
   endfunction

   task automatic random_ticks(int n);
      tick_type t;
      for (int i = 0; i < n; i++) begin
         t.tx_byte = 8'($urandom);
         t.ack_to_send = 1'($urandom);
         t.sda_sample = 1'($urandom);
         if (sb.busy) begin
            t.start = $urandom_range(0, 3) == 0;
            t.opcode = 3'($urandom);
         end else begin
            t.start = $urandom_range(0, 9) < 8;
            t.opcode = t.start ? next_opcode() : 3'($urandom);
         end
         send_tick(t);
      end
   endtask

   // finish the running command, drain, then write hold_ticks
   task automatic set_hold(logic [15:0] value);
      tick_type t;
      t = '0;
      while (sb.busy) begin
         t.sda_sample = 1'($urandom);
         send_tick(t);
      end
      req_push <= 1'b0;
      while (sb.pins_due.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_hold_ticks <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      sb.hold_ticks = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      req_push = 1'b0;
      req_cmd_valid = 1'b0;
      req_opcode = OP_START;
      req_tx_byte = 8'd0;
      req_ack_to_send = 1'b0;
      req_sda_sample = 1'b0;
      csr_valid = 1'b0;
      csr_hold_ticks = 16'd0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset hold value
      run_cmd(OP_START, 8'h00, 1'b0, 2, 1'b0);
      run_cmd(OP_SEND_BYTE, 8'hA5, 1'b0, 2, 1'b0);
      run_cmd(OP_RECV_ACK, 8'h00, 1'b0, 0, 1'b0);
      run_cmd(OP_RECV_BYTE, 8'h00, 1'b0, 2, 1'b1);
      run_cmd(OP_SEND_ACK, 8'h00, 1'b1, 2, 1'b0);
      run_cmd(OP_STOP, 8'h00, 1'b0, 1, 1'b0);

      set_hold(16'd1);
      run_cmd(OP_RSVD_6, 8'hFF, 1'b1, 1, 1'b0);
      run_cmd(OP_RSVD_7, 8'h00, 1'b0, 0, 1'b0);
      run_cmd(OP_START, 8'h00, 1'b0, 2, 1'b1);
      run_cmd(OP_SEND_BYTE, 8'h00, 1'b0, 2, 1'b0);
      run_cmd(OP_SEND_BYTE, 8'hFF, 1'b1, 2, 1'b1);
      run_cmd(OP_RECV_BYTE, 8'h00, 1'b0, 1, 1'b0);
      run_cmd(OP_RECV_BYTE, 8'h00, 1'b0, 0, 1'b1);
      run_cmd(OP_SEND_ACK, 8'h00, 1'b0, 2, 1'b0);
      run_cmd(OP_SEND_ACK, 8'h00, 1'b1, 2, 1'b1);
      run_cmd(OP_RECV_ACK, 8'h00, 1'b0, 1, 1'b0);
      run_cmd(OP_RECV_ACK, 8'h00, 1'b0, 0, 1'b1);
      run_cmd(OP_STOP, 8'h00, 1'b0, 2, 1'b1);
      random_ticks(250);

      set_hold(16'd0);
      random_ticks(200);
      set_hold(16'd2);
      random_ticks(200);
      set_hold(16'd3);
      random_ticks(150);
      set_hold(16'($urandom_range(4, 9)));
      random_ticks(150);

      // longest hold: the phase timer counts down from hold_ticks minus one
      set_hold(16'hFFFF);
      random_ticks(100);

      req_push <= 1'b0;
      while (sb.pins_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
